// File: rtl/u8u16_pkg.sv
package u8u16_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] UNIT_REPLACE = 16'hFFFD;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;
	localparam logic [15:0] SURR_HIGH    = 16'hD800;
	localparam logic [15:0] SURR_LOW     = 16'hDC00;

	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_ASCII = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	// One input byte worth of output: rep_cnt replacement units first,
	// then tail_cnt units taken from unit0 and unit1.
	typedef struct packed {
		logic [2:0]  rep_cnt;
		logic [1:0]  tail_cnt;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic        fin;
	} unit_desc_t;

	// Sequence length from bits 7..3 of a lead byte.
	function automatic logic [2:0] seq_len(input logic [4:0] top5);
		logic [2:0] len;
		case (top5) inside
			[5'd0:5'd15]:  len = LEN_ASCII;
			[5'd24:5'd27]: len = LEN_TWO;
			[5'd28:5'd29]: len = LEN_THREE;
			5'd30:         len = LEN_FOUR;
			default:       len = LEN_NONE;
		endcase
		return len;
	endfunction

endpackage

// File: rtl/u8u16_in_if.sv
interface u8u16_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

// File: rtl/u8u16_out_if.sv
interface u8u16_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        run_end;
	logic        text_end;

	modport source (output valid, output code_unit, output run_end, output text_end,
		input ready);
	modport sink (input valid, input code_unit, input run_end, input text_end,
		output ready);
endinterface

// File: rtl/u8u16_front.sv
module u8u16_front (
	input  logic                  clk,
	input  logic                  arst_n,
	u8u16_in_if.sink              in_ch,
	input  logic                  queue_full,
	output logic                  push,
	output u8u16_pkg::unit_desc_t push_desc
);

	logic [2:0]  exp_len_q;
	logic [1:0]  gath_q;
	logic [20:0] pc_q;

	logic [2:0]  nxt_len;
	logic [1:0]  nxt_gath;
	logic [20:0] nxt_pc;
	logic [2:0]  rep;
	logic [1:0]  tail;
	logic [15:0] u0;
	logic [15:0] u1;
	logic        fresh;
	logic        is_cont;
	logic [2:0]  g;
	logic [20:0] new_pc;
	logic [20:0] v;
	logic [2:0]  len;
	logic        accept;

	assign in_ch.ready = !queue_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_cont     = in_ch.text_byte[7:6] == 2'b10;
	assign g           = {1'b0, gath_q} + 3'd1;
	assign new_pc      = {pc_q[14:0], in_ch.text_byte[5:0]};
	assign v           = new_pc - u8u16_pkg::SUPP_BASE;
	assign len         = u8u16_pkg::seq_len(in_ch.text_byte[7:3]);

	always_comb begin
		nxt_len  = exp_len_q;
		nxt_gath = gath_q;
		nxt_pc   = pc_q;
		rep      = 3'd0;
		tail     = 2'd0;
		u0       = '0;
		u1       = '0;
		fresh    = 1'b1;

		if (exp_len_q != u8u16_pkg::LEN_NONE) begin
			if (is_cont) begin
				fresh  = 1'b0;
				nxt_pc = new_pc;
				if (g >= exp_len_q) begin
					if (new_pc < u8u16_pkg::SUPP_BASE) begin
						tail = 2'd1;
						u0   = new_pc[15:0];
					end else begin
						tail = 2'd2;
						u0   = u8u16_pkg::SURR_HIGH + {5'd0, v[20:10]};
						u1   = u8u16_pkg::SURR_LOW + {6'd0, v[9:0]};
					end
					nxt_len  = u8u16_pkg::LEN_NONE;
					nxt_gath = 2'd0;
					nxt_pc   = '0;
				end else begin
					nxt_gath = g[1:0];
				end
			end else begin
				// interrupted: one replacement per collected byte
				rep      = {1'b0, gath_q};
				nxt_len  = u8u16_pkg::LEN_NONE;
				nxt_gath = 2'd0;
				nxt_pc   = '0;
			end
		end

		if (fresh) begin
			case (len)
				u8u16_pkg::LEN_NONE: begin
					rep = rep + 3'd1;
				end
				u8u16_pkg::LEN_ASCII: begin
					tail = 2'd1;
					u0   = {9'd0, in_ch.text_byte[6:0]};
				end
				u8u16_pkg::LEN_TWO: begin
					nxt_len  = len;
					nxt_gath = 2'd1;
					nxt_pc   = {16'd0, in_ch.text_byte[4:0]};
				end
				u8u16_pkg::LEN_THREE: begin
					nxt_len  = len;
					nxt_gath = 2'd1;
					nxt_pc   = {17'd0, in_ch.text_byte[3:0]};
				end
				default: begin
					nxt_len  = len;
					nxt_gath = 2'd1;
					nxt_pc   = {18'd0, in_ch.text_byte[2:0]};
				end
			endcase
		end

		// truncated text: flush what is still pending
		if (in_ch.final_byte && nxt_len != u8u16_pkg::LEN_NONE) begin
			rep      = rep + {1'b0, nxt_gath};
			nxt_len  = u8u16_pkg::LEN_NONE;
			nxt_gath = 2'd0;
			nxt_pc   = '0;
		end
	end

	assign push               = accept && (rep != 3'd0 || tail != 2'd0);
	assign push_desc.rep_cnt  = rep;
	assign push_desc.tail_cnt = tail;
	assign push_desc.unit0    = u0;
	assign push_desc.unit1    = u1;
	assign push_desc.fin      = in_ch.final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= u8u16_pkg::LEN_NONE;
			gath_q    <= 2'd0;
			pc_q      <= '0;
		end else if (accept) begin
			exp_len_q <= nxt_len;
			gath_q    <= nxt_gath;
			pc_q      <= nxt_pc;
		end
	end

endmodule

// File: rtl/u8u16_queue.sv
module u8u16_queue #(
	parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  u8u16_pkg::unit_desc_t push_desc,
	input  logic                  pop,
	output logic                  full,
	output logic                  not_empty,
	output u8u16_pkg::unit_desc_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u8u16_pkg::unit_desc_t slot_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/u8u16_back.sv
module u8u16_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  u8u16_pkg::unit_desc_t head,
	output logic                  pop,
	u8u16_out_if.source           out_ch
);

	logic [1:0]  pos_q;
	logic        valid_q;
	logic [15:0] code_q;
	logic        run_end_q;
	logic        text_end_q;

	logic [2:0]  total;
	logic [2:0]  sel;
	logic        last;
	logic        load;
	logic [15:0] cur_unit;

	assign total = head.rep_cnt + {1'b0, head.tail_cnt};
	assign sel   = {1'b0, pos_q} - head.rep_cnt;
	assign last  = ({1'b0, pos_q} + 3'd1) == total;
	assign load  = head_valid && (!valid_q || out_ch.ready);
	assign pop   = load && last;

	always_comb begin
		if ({1'b0, pos_q} < head.rep_cnt) begin
			cur_unit = u8u16_pkg::UNIT_REPLACE;
		end else if (sel[0]) begin
			cur_unit = head.unit1;
		end else begin
			cur_unit = head.unit0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				pos_q   <= last ? 2'd0 : pos_q + 2'd1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q     <= cur_unit;
			run_end_q  <= last;
			text_end_q <= head.fin;
		end
	end

	assign out_ch.valid     = valid_q;
	assign out_ch.code_unit = code_q;
	assign out_ch.run_end   = run_end_q;
	assign out_ch.text_end  = text_end_q;

endmodule

// File: rtl/utf8_to_utf16_transcoder_core.sv
// channel  | role   | payload
// in_ch    | sink   | text_byte[7:0], final_byte
// out_ch   | source | code_unit[15:0], run_end, text_end
//
// One byte is taken per cycle while the queue has room; each byte yields zero
// to four units, sent one per cycle from the output register while out_ch is
// ready. The descriptor queue (QUEUE_DEPTH entries) lets the front
// keep taking bytes while the back end drains a burst or out_ch stalls.
// in_ch.ready drops only when the queue is full. Reset clears the pending
// sequence, the queue and the output register; no clearing pass is needed.
module utf8_to_utf16_transcoder_core #(
	parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	u8u16_in_if.sink    in_ch,
	u8u16_out_if.source out_ch
);

	logic                  push;
	logic                  pop;
	logic                  queue_full;
	logic                  head_valid;
	u8u16_pkg::unit_desc_t push_desc;
	u8u16_pkg::unit_desc_t head;

	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.queue_full (queue_full),
		.push       (push),
		.push_desc  (push_desc)
	);

	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (head_valid),
		.head      (head)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

// File: rtl/u8u16_checker.sv
module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic        run_end,
	input logic        text_end
);

	// hold a stalled unit
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit)
			&& $stable(run_end) && $stable(text_end))
		else $error("stalled output unit changed");

	// the rest of a run follows at once, with the same end-of-text mark
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_end |=> out_valid && $stable(text_end))
		else $error("run broken after a non-final unit");

	// a full queue means the output register is busy
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled while output is empty");

	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.code_unit (out_ch.code_unit),
	.run_end   (out_ch.run_end),
	.text_end  (out_ch.text_end)
);
